[sv/srect_pkg.sv]
package srect_pkg;

	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS - 1;

	localparam int IN_BITS    = 6 * COORD_BITS + 2 * SIZE_BITS;
	localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W  = 8;

	localparam int OFF_AX     = 0;
	localparam int OFF_AY     = COORD_BITS;
	localparam int OFF_BX     = 2 * COORD_BITS;
	localparam int OFF_BY     = 3 * COORD_BITS;
	localparam int OFF_LEFT   = 4 * COORD_BITS;
	localparam int OFF_TOP    = 5 * COORD_BITS;
	localparam int OFF_WIDTH  = 6 * COORD_BITS;
	localparam int OFF_HEIGHT = 6 * COORD_BITS + SIZE_BITS;

	localparam int DW = COORD_BITS + 2;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;

	localparam int NUM_EDGES   = 4;
	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_TOP    = 2;
	localparam int EDGE_BOTTOM = 3;

	typedef struct packed {
		logic signed [DW-1:0] a1;
		logic signed [DW-1:0] b1;
		logic signed [DW-1:0] a2;
		logic signed [DW-1:0] b2;
		logic signed [DW-1:0] c1;
		logic signed [DW-1:0] c2;
	} edge_ops_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	function automatic logic unit_ratio(input logic signed [NW-1:0] n,
			input logic signed [NW-1:0] d);
		logic signed [NW:0] diff;
		logic               res;
		diff = (NW+1)'(d) - (NW+1)'(n);
		if (d[NW-1]) begin
			res = (n[NW-1] || (n == '0)) && (diff[NW] || (diff == '0));
		end else begin
			res = !n[NW-1] && !diff[NW];
		end
		return res;
	endfunction

endpackage

[sv/srect_front.sv]
module srect_front import srect_pkg::*; (
	input  logic                         clk,
	input  logic [S_TDATA_W-1:0]         s_tdata,
	input  pipe_en_t                     en,
	output edge_ops_t [NUM_EDGES-1:0]    ops_s2,
	output logic                         inside_s2
);

	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, bx_s1, by_s1, l_s1, t_s1;
	logic [SIZE_BITS-1:0]         w_s1, h_s1;

	logic signed [DW-1:0] ax_w, ay_w, bx_w, by_w, l_w, t_w, r_w, b_w;
	logic signed [DW-1:0] w_w, h_w;
	logic signed [DW-1:0] x3 [NUM_EDGES];
	logic signed [DW-1:0] y3 [NUM_EDGES];
	logic signed [DW-1:0] x4 [NUM_EDGES];
	logic signed [DW-1:0] y4 [NUM_EDGES];
	edge_ops_t [NUM_EDGES-1:0] ops_d;
	logic in_a, in_b;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ax_s1 <= s_tdata[OFF_AX +: COORD_BITS];
			ay_s1 <= s_tdata[OFF_AY +: COORD_BITS];
			bx_s1 <= s_tdata[OFF_BX +: COORD_BITS];
			by_s1 <= s_tdata[OFF_BY +: COORD_BITS];
			l_s1  <= s_tdata[OFF_LEFT +: COORD_BITS];
			t_s1  <= s_tdata[OFF_TOP +: COORD_BITS];
			w_s1  <= s_tdata[OFF_WIDTH +: SIZE_BITS];
			h_s1  <= s_tdata[OFF_HEIGHT +: SIZE_BITS];
		end
	end

	assign ax_w = DW'(ax_s1);
	assign ay_w = DW'(ay_s1);
	assign bx_w = DW'(bx_s1);
	assign by_w = DW'(by_s1);
	assign l_w  = DW'(l_s1);
	assign t_w  = DW'(t_s1);
	assign w_w  = DW'(w_s1);
	assign h_w  = DW'(h_s1);
	assign r_w  = l_w + w_w;
	assign b_w  = t_w + h_w;

	assign in_a = (ax_w >= l_w) && (ay_w >= t_w) && (ax_w <= r_w) && (ay_w <= b_w);
	assign in_b = (bx_w >= l_w) && (by_w >= t_w) && (bx_w <= r_w) && (by_w <= b_w);

	always_comb begin
		x3[EDGE_LEFT]   = l_w; y3[EDGE_LEFT]   = t_w; x4[EDGE_LEFT]   = l_w; y4[EDGE_LEFT]   = b_w;
		x3[EDGE_RIGHT]  = r_w; y3[EDGE_RIGHT]  = t_w; x4[EDGE_RIGHT]  = r_w; y4[EDGE_RIGHT]  = b_w;
		x3[EDGE_TOP]    = l_w; y3[EDGE_TOP]    = t_w; x4[EDGE_TOP]    = r_w; y4[EDGE_TOP]    = t_w;
		x3[EDGE_BOTTOM] = l_w; y3[EDGE_BOTTOM] = b_w; x4[EDGE_BOTTOM] = r_w; y4[EDGE_BOTTOM] = b_w;
		for (int e = 0; e < NUM_EDGES; e++) begin
			ops_d[e].a1 = bx_w - ax_w;
			ops_d[e].b1 = by_w - ay_w;
			ops_d[e].a2 = x4[e] - x3[e];
			ops_d[e].b2 = y4[e] - y3[e];
			ops_d[e].c1 = ax_w - x3[e];
			ops_d[e].c2 = ay_w - y3[e];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ops_s2    <= ops_d;
			inside_s2 <= in_a || in_b;
		end
	end

endmodule

[sv/srect_cross.sv]
module srect_cross import srect_pkg::*; (
	input  logic      clk,
	input  pipe_en_t  en,
	input  edge_ops_t ops_s2,
	output logic      cross_s5
);

	logic signed [PW-1:0] p_a1b2_s3, p_a2b1_s3, p_a2c2_s3, p_b2c1_s3, p_a1c2_s3, p_b1c1_s3;
	logic signed [NW-1:0] d_s4, na_s4, nb_s4;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			p_a1b2_s3 <= PW'($signed(ops_s2.a1)) * PW'($signed(ops_s2.b2));
			p_a2b1_s3 <= PW'($signed(ops_s2.a2)) * PW'($signed(ops_s2.b1));
			p_a2c2_s3 <= PW'($signed(ops_s2.a2)) * PW'($signed(ops_s2.c2));
			p_b2c1_s3 <= PW'($signed(ops_s2.b2)) * PW'($signed(ops_s2.c1));
			p_a1c2_s3 <= PW'($signed(ops_s2.a1)) * PW'($signed(ops_s2.c2));
			p_b1c1_s3 <= PW'($signed(ops_s2.b1)) * PW'($signed(ops_s2.c1));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			d_s4  <= NW'(p_a1b2_s3) - NW'(p_a2b1_s3);
			na_s4 <= NW'(p_a2c2_s3) - NW'(p_b2c1_s3);
			nb_s4 <= NW'(p_a1c2_s3) - NW'(p_b1c1_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			cross_s5 <= (d_s4 != '0) && unit_ratio(na_s4, d_s4) && unit_ratio(nb_s4, d_s4);
		end
	end

endmodule

[sv/segment_rect_intersect_top.sv]
// Segment versus axis-aligned rectangle hit test. Each transaction on the slave side carries
// one segment and one rectangle; exactly one transaction with the hit flag follows on the
// master side, in order. hit is set when either endpoint lies in the closed rectangle, or
// when the segment crosses any of its edges (a parallel edge never counts as crossed).
// The crossing test is exact integer arithmetic, with no division. One transaction can be
// taken every cycle while the master side does not stall: the input register takes the
// transaction, then the operand, multiply, subtract, ratio-check and output stages follow
// in order. Stalls on the master side propagate backwards and empty stages are filled
// while the output waits.
module segment_rect_intersect_top import srect_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// ax, ay, bx, by, left, top (signed), width, height (unsigned), zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hit, zero pad
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	pipe_en_t en;

	edge_ops_t [NUM_EDGES-1:0] ops_s2;
	logic inside_s2, inside_s3, inside_s4, inside_s5;
	logic [NUM_EDGES-1:0] cross_s5;
	logic hit_s6;

	assign rdy6 = !vld_s6 || m_tready;
	assign rdy5 = !vld_s5 || rdy6;
	assign rdy4 = !vld_s4 || rdy5;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign s_tready = rdy1;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;
	assign en.s5 = rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	srect_front u_front (
		.clk       (clk),
		.s_tdata   (s_tdata),
		.en        (en),
		.ops_s2    (ops_s2),
		.inside_s2 (inside_s2)
	);

	for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
		srect_cross u_cross (
			.clk      (clk),
			.en       (en),
			.ops_s2   (ops_s2[e]),
			.cross_s5 (cross_s5[e])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy3) inside_s3 <= inside_s2;
		if (rdy4) inside_s4 <= inside_s3;
		if (rdy5) inside_s5 <= inside_s4;
		if (rdy6) hit_s6    <= inside_s5 || (|cross_s5);
	end

	assign m_tvalid = vld_s6;
	assign m_tdata  = {(M_TDATA_W-1)'(0), hit_s6};

endmodule

[tb/sv/segment_rect_intersect_top_tb.sv]
module segment_rect_intersect_top_tb import srect_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 400;
	localparam int RANDOM_ITEMS = 600;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	bit no_idle;
	int results_taken;
	int cycle_count;

	class hit_scoreboard;
		bit expected_hits[$];
		int fails;

		function new();
			fails = 0;
		endfunction

		static function bit in_unit(longint n, longint d);
			longint diff;
			diff = d - n;
			if (d < 0) begin
				return (n <= 0) && (diff <= 0);
			end
			return (n >= 0) && (diff >= 0);
		endfunction

		static function bit crosses_edge(longint x1, longint y1, longint x2, longint y2,
				longint x3, longint y3, longint x4, longint y4);
			longint a1, a2, b1, b2, c1, c2, den, num_a, num_b;
			a1 = x2 - x1;
			a2 = x4 - x3;
			b1 = y2 - y1;
			b2 = y4 - y3;
			c1 = x1 - x3;
			c2 = y1 - y3;
			den   = a1 * b2 - a2 * b1;
			num_a = a2 * c2 - b2 * c1;
			num_b = a1 * c2 - b1 * c1;
			// parallel or collinear edge never counts as crossed
			if (den == 0) begin
				return 1'b0;
			end
			return in_unit(num_a, den) && in_unit(num_b, den);
		endfunction

		function void note_segment(logic [S_TDATA_W-1:0] v);
			longint ax, ay, bx, by, lx, ty, rx, by_far;
			bit     hit;
			ax = longint'($signed(v[OFF_AX +: COORD_BITS]));
			ay = longint'($signed(v[OFF_AY +: COORD_BITS]));
			bx = longint'($signed(v[OFF_BX +: COORD_BITS]));
			by = longint'($signed(v[OFF_BY +: COORD_BITS]));
			lx = longint'($signed(v[OFF_LEFT +: COORD_BITS]));
			ty = longint'($signed(v[OFF_TOP +: COORD_BITS]));
			rx = lx + longint'(v[OFF_WIDTH +: SIZE_BITS]);
			by_far = ty + longint'(v[OFF_HEIGHT +: SIZE_BITS]);
			if ((ax >= lx && ay >= ty && ax <= rx && ay <= by_far) ||
					(bx >= lx && by >= ty && bx <= rx && by <= by_far)) begin
				hit = 1'b1;
			end else begin
				hit = crosses_edge(ax, ay, bx, by, lx, ty, lx, by_far) ||
					crosses_edge(ax, ay, bx, by, rx, ty, rx, by_far) ||
					crosses_edge(ax, ay, bx, by, lx, ty, rx, ty) ||
					crosses_edge(ax, ay, bx, by, lx, by_far, rx, by_far);
			end
			expected_hits.push_back(hit);
		endfunction

		function void check_hit(logic [M_TDATA_W-1:0] v);
			bit want;
			if (expected_hits.size() == 0) begin
				$error("hit: unexpected transaction, expected none, actual %0d", v[0]);
				fails++;
				return;
			end
			want = expected_hits.pop_front();
			if (v[0] !== want) begin
				$error("hit: expected %0d, actual %0d", want, v[0]);
				fails++;
			end
			if (v[M_TDATA_W-1:1] !== '0) begin
				$error("pad: expected 0, actual %0h", v[M_TDATA_W-1:1]);
				fails++;
			end
		endfunction

		function int pending();
			return expected_hits.size();
		endfunction
	endclass

	hit_scoreboard ledger = new();

	segment_rect_intersect_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			ledger.note_segment(s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			ledger.check_hit(m_tdata);
			results_taken++;
		end
	end

	task automatic push_segment(input int ax, input int ay, input int bx, input int by,
			input int lx, input int ty, input int w, input int h);
		int gap;
		bit taken;
		logic [S_TDATA_W-1:0] v;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		v = '0;
		v[OFF_AX +: COORD_BITS]    = ax[COORD_BITS-1:0];
		v[OFF_AY +: COORD_BITS]    = ay[COORD_BITS-1:0];
		v[OFF_BX +: COORD_BITS]    = bx[COORD_BITS-1:0];
		v[OFF_BY +: COORD_BITS]    = by[COORD_BITS-1:0];
		v[OFF_LEFT +: COORD_BITS]  = lx[COORD_BITS-1:0];
		v[OFF_TOP +: COORD_BITS]   = ty[COORD_BITS-1:0];
		v[OFF_WIDTH +: SIZE_BITS]  = w[SIZE_BITS-1:0];
		v[OFF_HEIGHT +: SIZE_BITS] = h[SIZE_BITS-1:0];
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = s_tready;
		end
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic int pick_size();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 1;
			default: return 32767;
		endcase
	endfunction

	// receiver: random stalls, one long hold-off so the pipeline backs up
	initial begin
		int stall;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_taken >= 150) begin
				held = 1'b1;
				stall = LONG_HOLD;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 5);
			end
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!m_tvalid);
		end
	end

	initial begin
		int kind, lx, ty, w, h;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		no_idle  = 1'b0;
		results_taken = 0;
		cycle_count = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_segment(2, 3, 50, 60, 0, 0, 10, 10);
		push_segment(-50, -7, 5, 5, 0, 0, 10, 10);
		push_segment(10, 10, 30, 40, 0, 0, 10, 10);
		push_segment(-5, 5, 0, 5, 0, 0, 10, 10);
		push_segment(-5, 5, 15, 5, 0, 0, 10, 10);
		push_segment(-5, 0, 15, 0, 0, 0, 10, 10);
		push_segment(-5, -3, 15, -3, 0, 0, 10, 10);
		push_segment(20, 20, 20, 20, 0, 0, 10, 10);
		push_segment(4, 4, 4, 4, 0, 0, 10, 10);
		push_segment(-5, 5, 5, -5, 0, 0, 10, 10);
		push_segment(-5, 3, 5, 3, 0, 0, 0, 10);
		push_segment(3, -5, 3, 5, 0, 0, 10, 0);
		push_segment(-5, -5, 5, 5, 0, 0, 0, 0);
		push_segment(-5, -4, 5, 6, 0, 0, 0, 0);
		push_segment(100, 100, 200, 50, 0, 0, 10, 10);
		push_segment(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
		push_segment(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
		push_segment(32767, -32768, 32767, 32767, -32768, -32768, 0, 0);
		push_segment(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0);
		push_segment(0, -32768, 0, 32767, -32768, 0, 32767, 32767);
		push_segment(-32768, 0, 32767, 0, 32767, -32768, 0, 32767);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = (i >= 300 && i < 380);
			kind = $urandom_range(0, 9);
			if (kind <= 2) begin
				push_segment($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end else if (kind <= 5) begin
				// tight grid: collinear, parallel and degenerate cases are common
				lx = $urandom_range(0, 20) - 10;
				ty = $urandom_range(0, 20) - 10;
				w  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
				h  = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
				if ($urandom_range(0, 7) == 0) begin
					kind = $urandom_range(0, 40) - 20;
					push_segment(kind, kind, kind, kind, lx, ty, w, h);
				end else begin
					push_segment($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
						$urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
						lx, ty, w, h);
				end
			end else if (kind <= 8) begin
				// endpoints spread around a mid-sized box so many segments cross it
				lx = $urandom_range(0, 40000) - 20000;
				ty = $urandom_range(0, 40000) - 20000;
				w  = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 3000);
				h  = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 3000);
				push_segment(lx - w - 50 + $urandom_range(0, 3 * w + 100),
					ty - h - 50 + $urandom_range(0, 3 * h + 100),
					lx - w - 50 + $urandom_range(0, 3 * w + 100),
					ty - h - 50 + $urandom_range(0, 3 * h + 100),
					lx, ty, w, h);
			end else begin
				push_segment(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
					pick_extreme(), pick_extreme(), pick_size(), pick_size());
			end
		end
		no_idle = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (ledger.pending() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (ledger.fails == 0 && ledger.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[sim.f]
sv/srect_pkg.sv
sv/srect_front.sv
sv/srect_cross.sv
sv/segment_rect_intersect_top.sv
tb/sv/segment_rect_intersect_top_tb.sv
